// File: sv/slq_pkg.sv
// Shared types and codes for the sorted list queue engine.
`timescale 1ns / 1ps

package slq_pkg;

  localparam logic [2:0] FN_PUSH   = 3'd0;
  localparam logic [2:0] FN_POP    = 3'd1;
  localparam logic [2:0] FN_INSERT = 3'd2;
  localparam logic [2:0] FN_ERASE  = 3'd3;
  localparam logic [2:0] FN_GET    = 3'd4;
  localparam logic [2:0] FN_SIZE   = 3'd5;
  localparam logic [2:0] FN_CLEAR  = 3'd6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NEG  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_SEARCH,
    MD_SHIFT,
    MD_DROP_HEAD,
    MD_ERASE
  } slq_mode_t;

  typedef struct packed {
    logic      load;
    slq_mode_t mode;
    logic      shift_init;
    logic      place;
    logic      commit_keep;
    logic      clear;
    logic      take_rd;
    logic      res_load;
  } slq_cmd_t;

  typedef struct packed {
    logic neg_val;
    logic neg_pos;
    logic full;
    logic empty;
    logic oob;
    logic found;
    logic scan_done;
    logic hit;
  } slq_sts_t;

endpackage

// File: sv/slq_datapath.sv
// Datapath: entry memory, count, walk indices and result data register.
`timescale 1ns / 1ps

module slq_datapath import slq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  slq_cmd_t    cmd,
  input  logic [31:0] in_value,
  input  logic [31:0] in_position,
  output slq_sts_t    sts,
  output logic [31:0] res_value,
  output logic [6:0]  res_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  logic [30:0]   mem [DEPTH];
  logic [30:0]   rdata_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          s1_vld_r, s1_vld_nxt;
  logic [CW-1:0] s1_idx_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] keep_r, keep_nxt;
  logic [CW-1:0] at_r, at_nxt;
  logic          hit_r, hit_nxt;
  logic [30:0]   val_r;
  logic          vneg_r;
  logic [31:0]   pos_r;
  logic [31:0]   rd_r, rd_nxt;
  logic [31:0]   out_value_r;
  logic [6:0]    out_count_r;
  logic [31:0]   cnt_ext;
  logic [CW-1:0] idx_dec;

  logic          scan_mode, issue, drop, found;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [30:0]   wdata;

  assign scan_mode = (cmd.mode == MD_SEARCH) || (cmd.mode == MD_DROP_HEAD) ||
                     (cmd.mode == MD_ERASE);
  assign issue = (scan_mode && (idx_r < cnt_r)) ||
                 ((cmd.mode == MD_SHIFT) && (idx_r > at_r));
  assign idx_dec = idx_r - CW'(1);
  assign found = (cmd.mode == MD_SEARCH) && s1_vld_r && (rdata_r <= val_r);
  assign drop  = s1_vld_r &&
                 (((cmd.mode == MD_DROP_HEAD) && (s1_idx_r == '0)) ||
                  ((cmd.mode == MD_ERASE) && (rdata_r == val_r)));
  assign cnt_ext = 32'(cnt_r);

  always_comb begin
    if (cmd.mode == MD_SHIFT) begin
      raddr = idx_dec[AW-1:0];
    end else if (scan_mode) begin
      raddr = idx_r[AW-1:0];
    end else begin
      raddr = pos_r[AW-1:0];
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    keep_nxt   = keep_r;
    at_nxt     = at_r;
    hit_nxt    = hit_r;
    rd_nxt     = rd_r;
    s1_vld_nxt = issue && !cmd.shift_init;
    we         = 1'b0;
    waddr      = keep_r[AW-1:0];
    wdata      = rdata_r;

    if (issue) begin
      idx_nxt = (cmd.mode == MD_SHIFT) ? idx_dec : idx_r + CW'(1);
    end
    if (cmd.mode == MD_SHIFT && s1_vld_r) begin
      we    = 1'b1;
      waddr = s1_idx_r[AW-1:0];
    end
    if ((cmd.mode == MD_DROP_HEAD || cmd.mode == MD_ERASE) && s1_vld_r) begin
      if (drop) begin
        hit_nxt = 1'b1;
        if (cmd.mode == MD_DROP_HEAD) begin
          rd_nxt = {1'b0, rdata_r};
        end
      end else begin
        we       = 1'b1;
        waddr    = keep_r[AW-1:0];
        keep_nxt = keep_r + CW'(1);
      end
    end
    if (cmd.shift_init) begin
      idx_nxt = cnt_r;
      if (found) begin
        at_nxt = s1_idx_r;
      end
    end
    if (cmd.place) begin
      we      = 1'b1;
      waddr   = at_r[AW-1:0];
      wdata   = val_r;
      cnt_nxt = cnt_r + CW'(1);
    end
    if (cmd.commit_keep) begin
      cnt_nxt = keep_r;
    end
    if (cmd.clear) begin
      cnt_nxt = '0;
    end
    if (cmd.take_rd) begin
      rd_nxt = {1'b0, rdata_r};
    end
    if (cmd.load) begin
      idx_nxt  = '0;
      keep_nxt = '0;
      hit_nxt  = 1'b0;
      at_nxt   = cnt_r;
      rd_nxt   = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= idx_r;
    idx_r    <= idx_nxt;
    keep_r   <= keep_nxt;
    at_r     <= at_nxt;
    hit_r    <= hit_nxt;
    rd_r     <= rd_nxt;
    if (cmd.load) begin
      val_r  <= in_value[30:0];
      vneg_r <= in_value[31];
      pos_r  <= in_position;
    end
    if (cmd.res_load) begin
      out_value_r <= rd_r;
      out_count_r <= cnt_ext[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign sts.neg_val   = vneg_r;
  assign sts.neg_pos   = pos_r[31];
  assign sts.full      = (cnt_r == CW'(DEPTH));
  assign sts.empty     = (cnt_r == '0);
  assign sts.oob       = (pos_r >= cnt_ext);
  assign sts.found     = found;
  assign sts.scan_done = !issue && !s1_vld_r;
  assign sts.hit       = hit_r;

  assign res_value = out_value_r;
  assign res_count = out_count_r;

endmodule

// File: sv/slq_ctrl.sv
// Controller: operation sequencing, result status and output handshake.
`timescale 1ns / 1ps

module slq_ctrl import slq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [2:0] in_func,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [1:0] out_status,
  input  slq_sts_t   sts,
  output slq_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SEARCH,
    S_SHIFT,
    S_PLACE,
    S_COMPACT,
    S_GET,
    S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] func_r, func_nxt;
  logic [1:0] st_r, st_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic [1:0] out_status_r, out_status_nxt;

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    st_nxt         = st_r;
    out_vld_nxt    = out_vld_r && !out_tready;
    out_status_nxt = out_status_r;
    cmd            = '0;
    cmd.mode       = MD_IDLE;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          func_nxt  = in_func;
          st_nxt    = ST_OK;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_FIN;
        case (func_r)
          FN_PUSH, FN_INSERT: begin
            if (sts.neg_val) begin
              st_nxt = ST_NEG;
            end else if (sts.full) begin
              st_nxt = ST_FULL;
            end else begin
              state_nxt = (func_r == FN_PUSH) ? S_PLACE : S_SEARCH;
            end
          end
          FN_POP: begin
            if (sts.empty) begin
              st_nxt = ST_MISS;
            end else begin
              state_nxt = S_COMPACT;
            end
          end
          FN_ERASE: begin
            if (sts.neg_val) begin
              st_nxt = ST_NEG;
            end else begin
              state_nxt = S_COMPACT;
            end
          end
          FN_GET: begin
            if (sts.neg_pos) begin
              st_nxt = ST_NEG;
            end else if (sts.oob) begin
              st_nxt = ST_MISS;
            end else begin
              state_nxt = S_GET;
            end
          end
          FN_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_SEARCH: begin
        cmd.mode = MD_SEARCH;
        if (sts.found || sts.scan_done) begin
          cmd.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.mode = MD_SHIFT;
        if (sts.scan_done) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_FIN;
      end
      S_COMPACT: begin
        cmd.mode = (func_r == FN_POP) ? MD_DROP_HEAD : MD_ERASE;
        if (sts.scan_done) begin
          cmd.commit_keep = 1'b1;
          st_nxt          = sts.hit ? ST_OK : ST_MISS;
          state_nxt       = S_FIN;
        end
      end
      S_GET: begin
        cmd.take_rd = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (!out_vld_r || out_tready) begin
          cmd.res_load   = 1'b1;
          out_vld_nxt    = 1'b1;
          out_status_nxt = st_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      func_r       <= FN_SIZE;
      st_r         <= ST_OK;
      out_vld_r    <= 1'b0;
      out_status_r <= ST_OK;
    end else begin
      state_r      <= state_nxt;
      func_r       <= func_nxt;
      st_r         <= st_nxt;
      out_vld_r    <= out_vld_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_status = out_status_r;

endmodule

// File: sv/sorted_list_queue_engine.sv
// Size, clear and rejected items finish after the decide step; push places the value and
// get reads one entry; pop and erase walk the entry memory, and insert searches and then
// shifts it, one entry per cycle; a result waits while the output holds an untaken one.
// Throughput: one item at a time; the next item is accepted the cycle after the previous
// result enters the output register, which holds it until taken.
// Reset clears the entry count and handshake state; the entry memory is not swept.
`timescale 1ns / 1ps

module sorted_list_queue_engine import slq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // value[31:0], position[63:32]
  input  logic [2:0]  in_tuser,   // func[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // read_value[31:0], entry_count[38:32], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);

  slq_cmd_t    cmd;
  slq_sts_t    sts;
  logic [31:0] res_value;
  logic [6:0]  res_count;

  slq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_tuser),
    .sts        (sts),
    .cmd        (cmd)
  );

  slq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_value    (in_tdata[31:0]),
    .in_position (in_tdata[63:32]),
    .sts         (sts),
    .res_value   (res_value),
    .res_count   (res_count)
  );

  assign out_tdata = {1'b0, res_count, res_value};

endmodule

// File: sv/slq_checker.sv
// Port-level checks for the sorted list queue engine, bound to the top level.
`timescale 1ns / 1ps

module slq_checker import slq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);

  localparam logic [31:0] DEPTH_W = 32'(DEPTH);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_fail_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata[31:0] == 32'hFFFF_FFFF)
    else $error("failed operation returned a value");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |-> out_tdata[38:32] == DEPTH_W[6:0])
    else $error("full status with count below depth");

endmodule

bind sorted_list_queue_engine slq_checker #(.DEPTH(DEPTH)) u_slq_checker (.*);
